[design/lsp_pkg.sv]
// shared types, widths and codes for the line sensor position block
package lsp_pkg;

  localparam int DEF_SAMPLE_BITS   = 12;
  localparam int DEF_FRACTION_BITS = 8;

  localparam int LEVEL_W = 10;
  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 10'd1000;
  localparam int SUM_W   = 12;
  localparam int POS_W   = 19;
  localparam int GAIN_W  = 10;
  localparam int THR_W   = 12;
  localparam int LOST_W  = 18;

  localparam logic [POS_W-1:0] Q_LIMIT = POS_W'(1) << (POS_W - 1);
  localparam logic [POS_W-1:0] POS_MAX = Q_LIMIT - POS_W'(1);

  localparam int OUT_DATA_W = ((POS_W + 3 * LEVEL_W + 7) / 8) * 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POSITION_GAIN  = 2'd0,
    REG_LINE_THRESHOLD = 2'd1,
    REG_LOST_DRIVE     = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIR_ZERO = 2'b00,
    DIR_POS  = 2'b01,
    DIR_NEG  = 2'b11
  } dir_t;

  localparam int CHAN_N = 3;
  localparam int CHAN_W = 2;
  typedef logic [CHAN_W-1:0] chan_t;
  localparam chan_t LAST_CH = chan_t'(CHAN_N - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CAL,
    S_PREP,
    S_DIV,
    S_DWAIT,
    S_SUM,
    S_PPREP,
    S_PCHK,
    S_PWAIT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic  load_in;
    logic  cal;
    logic  prep_scale;
    logic  div_start_scale;
    logic  level_wr;
    logic  sum;
    logic  prep_pos;
    logic  div_start_pos;
    logic  out_load;
    chan_t ch;
  } cmd_t;

  typedef struct packed {
    logic scale_byp;
    logic pos_byp;
    logic div_busy;
    logic out_free;
  } stat_t;

endpackage

[design/lsp_div.sv]
// shared restoring divider, one quotient bit per cycle
module lsp_div #(
  parameter int NUM_W = 28,
  parameter int DEN_W = 12
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       short_mode,
  input  logic [NUM_W-1:0]           num,
  input  logic [DEN_W-1:0]           den,
  output logic                       busy,
  output logic [lsp_pkg::POS_W-1:0]  quot
);
  import lsp_pkg::*;

  localparam int CNT_W = $clog2(POS_W + 1);

  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] low;
  logic [DEN_W-1:0] dsr;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   trial_sub;
  logic             fits;

  assign trial     = {rem, low[NUM_W-1]};
  assign fits      = trial >= {1'b0, dsr};
  assign trial_sub = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= short_mode ? CNT_W'(LEVEL_W) : CNT_W'(POS_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // quotient is known to fit, so the top bits seed the remainder
  always_ff @(posedge clk) begin
    if (start) begin
      dsr  <= den;
      quot <= '0;
      if (short_mode) begin
        rem <= DEN_W'(num >> LEVEL_W);
        low <= num << (NUM_W - LEVEL_W);
      end else begin
        rem <= DEN_W'(num >> POS_W);
        low <= num << (NUM_W - POS_W);
      end
    end else if (busy) begin
      rem  <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
      low  <= low << 1;
      quot <= {quot[POS_W-2:0], fits};
    end
  end

endmodule

[design/lsp_dp.sv]
// datapath: marks, levels, config registers, position math and result register
module lsp_dp #(
  parameter int SAMPLE_BITS   = lsp_pkg::DEF_SAMPLE_BITS,
  parameter int FRACTION_BITS = lsp_pkg::DEF_FRACTION_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  lsp_pkg::cmd_t                      cmd,
  output lsp_pkg::stat_t                     stat,
  input  logic [SAMPLE_BITS-1:0]             in_left,
  input  logic [SAMPLE_BITS-1:0]             in_center,
  input  logic [SAMPLE_BITS-1:0]             in_right,
  input  logic                               cfg_wr,
  input  logic [lsp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lsp_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [lsp_pkg::POS_W-1:0]   out_position,
  output logic                               out_present,
  output logic [lsp_pkg::LEVEL_W-1:0]        out_left,
  output logic [lsp_pkg::LEVEL_W-1:0]        out_center,
  output logic [lsp_pkg::LEVEL_W-1:0]        out_right
);
  import lsp_pkg::*;

  localparam int SNUM_W = SAMPLE_BITS + LEVEL_W;
  localparam int PROD_W = GAIN_W + LEVEL_W;
  localparam int PNUM_W = PROD_W + FRACTION_BITS;
  localparam int NUM_W  = (SNUM_W > PNUM_W) ? SNUM_W : PNUM_W;
  localparam int DEN_W  = (SAMPLE_BITS > SUM_W) ? SAMPLE_BITS : SUM_W;

  logic [SAMPLE_BITS-1:0] raw       [CHAN_N];
  logic [SAMPLE_BITS-1:0] low_mark  [CHAN_N];
  logic [SAMPLE_BITS-1:0] high_mark [CHAN_N];
  logic [LEVEL_W-1:0]     level     [CHAN_N];

  logic [GAIN_W-1:0] gain;
  logic [THR_W-1:0]  thr;
  logic [LOST_W-1:0] lost;

  logic [NUM_W-1:0]   num_reg;
  logic [DEN_W-1:0]   den_reg;
  logic               byp;
  logic [LEVEL_W-1:0] byp_val;
  logic [SUM_W-1:0]   total;
  logic               present;
  logic               neg;
  logic               pos_zero;
  dir_t               last_dir;

  logic [SAMPLE_BITS-1:0] v_sel, lo_sel, hi_sel;
  logic [SUM_W-1:0]       level_sum;
  logic [LEVEL_W-1:0]     ldiff;
  logic                   ldiff_neg;
  logic [PROD_W-1:0]      prod;
  logic                   ovf;
  logic                   div_busy;
  logic [POS_W-1:0]       quot;
  logic [POS_W-1:0]       qc;
  logic signed [POS_W-1:0] pos_calc;

  assign v_sel  = raw[cmd.ch];
  assign lo_sel = low_mark[cmd.ch];
  assign hi_sel = high_mark[cmd.ch];

  assign level_sum = SUM_W'(level[0]) + SUM_W'(level[1]) + SUM_W'(level[2]);
  assign ldiff_neg = level[0] > level[2];
  assign ldiff     = ldiff_neg ? (level[0] - level[2]) : (level[2] - level[0]);
  assign prod      = PROD_W'(gain) * PROD_W'(ldiff);

  // quotient would reach 2^POS_W or more
  assign ovf = (num_reg >> POS_W) >= NUM_W'(den_reg);

  assign stat.scale_byp = byp;
  assign stat.pos_byp   = !present || pos_zero || ovf;
  assign stat.div_busy  = div_busy;
  assign stat.out_free  = !out_valid || out_ready;

  lsp_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk        (clk),
    .rst        (rst),
    .start      (cmd.div_start_scale || cmd.div_start_pos),
    .short_mode (cmd.div_start_scale),
    .num        (num_reg),
    .den        (den_reg),
    .busy       (div_busy),
    .quot       (quot)
  );

  always_comb begin
    qc = (ovf || quot > Q_LIMIT) ? Q_LIMIT : quot;
    if (!present) begin
      case (last_dir)
        DIR_POS: pos_calc = POS_W'(lost);
        DIR_NEG: pos_calc = -POS_W'(lost);
        default: pos_calc = '0;
      endcase
    end else if (pos_zero) begin
      pos_calc = '0;
    end else if (neg) begin
      pos_calc = -qc;
    end else begin
      pos_calc = (qc == Q_LIMIT) ? POS_MAX : qc;
    end
  end

  // config registers, marks, direction and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      gain      <= GAIN_W'(1);
      thr       <= THR_W'(200);
      lost      <= LOST_W'(256);
      last_dir  <= DIR_ZERO;
      out_valid <= 1'b0;
      for (int i = 0; i < CHAN_N; i++) begin
        low_mark[i]  <= '1;
        high_mark[i] <= '0;
      end
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          REG_POSITION_GAIN:  gain <= cfg_data[GAIN_W-1:0];
          REG_LINE_THRESHOLD: thr  <= cfg_data[THR_W-1:0];
          REG_LOST_DRIVE:     lost <= cfg_data[LOST_W-1:0];
          default: ;
        endcase
      end
      if (cmd.cal) begin
        for (int i = 0; i < CHAN_N; i++) begin
          if (raw[i] < low_mark[i]) low_mark[i] <= raw[i];
          if (raw[i] > high_mark[i]) high_mark[i] <= raw[i];
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
        if (present) begin
          if (pos_zero) last_dir <= DIR_ZERO;
          else if (neg) last_dir <= DIR_NEG;
          else          last_dir <= DIR_POS;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      raw[0] <= in_left;
      raw[1] <= in_center;
      raw[2] <= in_right;
    end
    if (cmd.prep_scale) begin
      byp     <= (hi_sel <= lo_sel) || (v_sel < lo_sel) || (v_sel > hi_sel);
      byp_val <= ((hi_sel > lo_sel) && (v_sel > hi_sel)) ? LEVEL_FULL : '0;
      num_reg <= NUM_W'(SNUM_W'(v_sel - lo_sel) * SNUM_W'(LEVEL_FULL));
      den_reg <= DEN_W'(hi_sel - lo_sel);
    end
    if (cmd.level_wr) begin
      level[cmd.ch] <= byp ? byp_val : quot[LEVEL_W-1:0];
    end
    if (cmd.sum) begin
      total   <= level_sum;
      present <= level_sum >= thr;
    end
    if (cmd.prep_pos) begin
      neg      <= ldiff_neg;
      num_reg  <= NUM_W'({prod, {FRACTION_BITS{1'b0}}});
      den_reg  <= DEN_W'(total);
      pos_zero <= (ldiff == '0) || (gain == '0) || (total == '0);
    end
    if (cmd.out_load) begin
      out_position <= pos_calc;
      out_present  <= present;
      out_left     <= level[0];
      out_center   <= level[1];
      out_right    <= level[2];
    end
  end

endmodule

[design/lsp_ctrl.sv]
// controller state machine sequencing calibration and reads
module lsp_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_func,
  input  lsp_pkg::stat_t stat,
  output logic           in_ready,
  output lsp_pkg::cmd_t  cmd
);
  import lsp_pkg::*;

  state_t state, state_next;
  chan_t  ch, ch_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ch    <= '0;
    end else begin
      state <= state_next;
      ch    <= ch_next;
    end
  end

  always_comb begin
    state_next = state;
    ch_next    = ch;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = in_func ? S_PREP : S_CAL;
          ch_next    = '0;
        end
      end
      S_CAL:  state_next = S_IDLE;
      S_PREP: state_next = S_DIV;
      S_DIV: begin
        if (stat.scale_byp) begin
          if (ch == LAST_CH) begin
            state_next = S_SUM;
          end else begin
            ch_next    = ch + chan_t'(1);
            state_next = S_PREP;
          end
        end else begin
          state_next = S_DWAIT;
        end
      end
      S_DWAIT: begin
        if (!stat.div_busy) begin
          if (ch == LAST_CH) begin
            state_next = S_SUM;
          end else begin
            ch_next    = ch + chan_t'(1);
            state_next = S_PREP;
          end
        end
      end
      S_SUM:   state_next = S_PPREP;
      S_PPREP: state_next = S_PCHK;
      S_PCHK:  state_next = stat.pos_byp ? S_OUT : S_PWAIT;
      S_PWAIT: if (!stat.div_busy) state_next = S_OUT;
      S_OUT:   if (stat.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.ch   = ch;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      S_CAL:   cmd.cal = 1'b1;
      S_PREP:  cmd.prep_scale = 1'b1;
      S_DIV: begin
        cmd.level_wr        = stat.scale_byp;
        cmd.div_start_scale = !stat.scale_byp;
      end
      S_DWAIT: cmd.level_wr = !stat.div_busy;
      S_SUM:   cmd.sum = 1'b1;
      S_PPREP: cmd.prep_pos = 1'b1;
      S_PCHK:  cmd.div_start_pos = !stat.pos_byp;
      S_PWAIT: ;
      S_OUT:   cmd.out_load = stat.out_free;
      default: ;
    endcase
  end

endmodule

[design/line_sensor_position.sv]
// top level of the three-channel calibrated reflectance line locator
module line_sensor_position #(
  parameter int SAMPLE_BITS   = lsp_pkg::DEF_SAMPLE_BITS,
  parameter int FRACTION_BITS = lsp_pkg::DEF_FRACTION_BITS
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // input stream
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // left_raw, center_raw, right_raw, zero padding
  input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,
  // func: 0 calibrate, 1 read
  input  logic                                    s_axis_tuser,
  // result stream
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // position, left_level, center_level, right_level, zero padding
  output logic [lsp_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
  // line_present
  output logic                                    m_axis_tuser,
  // register writes
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [lsp_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [lsp_pkg::CFG_DATA_W-1:0]          cfg_data
);
  // Each transaction on the input stream carries three raw samples and a func
  // bit. A calibrate transaction (func 0) widens the per-channel min/max marks
  // and gives no result. A read transaction (func 1) scales each sample to
  // 0..1000 against its marks, sums the levels and, when the sum reaches
  // line_threshold, forms position = gain*(right-left)*2^FRACTION_BITS / sum
  // truncated toward zero, saturated to 19 bits signed; otherwise it gives the
  // remembered direction times lost_drive. One shared restoring divider makes
  // one quotient bit a cycle, 10 steps for each of the three levels and 19 for
  // the position, and the next transaction is accepted only after the read has
  // loaded its result. Channels whose level is fixed by the marks and lost-line
  // reads skip the divider and finish sooner. A waiting result sits in an
  // output register, so the next transaction is accepted while it waits; a
  // read that finishes before that result is taken holds in its last step
  // until it is. Register writes are taken at once.
  import lsp_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  logic signed [POS_W-1:0] position;
  logic [LEVEL_W-1:0]      left_level;
  logic [LEVEL_W-1:0]      center_level;
  logic [LEVEL_W-1:0]      right_level;
  logic                    line_present;

  // writes are always taken
  assign cfg_ready = 1'b1;

  lsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_func  (s_axis_tuser),
    .stat     (stat),
    .in_ready (s_axis_tready),
    .cmd      (cmd)
  );

  lsp_dp #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_left      (s_axis_tdata[SAMPLE_BITS-1:0]),
    .in_center    (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .in_right     (s_axis_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS]),
    .cfg_wr       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_position (position),
    .out_present  (line_present),
    .out_left     (left_level),
    .out_center   (center_level),
    .out_right    (right_level)
  );

  // pack result fields from the lowest bit up
  assign m_axis_tdata = OUT_DATA_W'({right_level, center_level, left_level, position});
  assign m_axis_tuser = line_present;

  // scaled levels never pass full scale
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (left_level <= LEVEL_FULL) && (center_level <= LEVEL_FULL)
                      && (right_level <= LEVEL_FULL))
    else $error("level above full scale");

  // balanced outer channels with a line give a centered position
  a_balanced_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && line_present && (left_level == right_level) |-> position == 0)
    else $error("balanced reading gave nonzero position");

  // position sign follows the stronger outer channel
  a_sign_right: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && line_present && (right_level > left_level) |-> position >= 0)
    else $error("right-heavy reading gave negative position");

  a_sign_left: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && line_present && (left_level > right_level) |-> position <= 0)
    else $error("left-heavy reading gave positive position");

endmodule
